// ----- rtl/sparse_polynomial_merge_add_unit_assert.svh -----
// assertion macros for the sparse polynomial merge adder
// bodies compile away under synthesis
`ifndef SPARSE_POLYNOMIAL_MERGE_ADD_UNIT_ASSERT_SVH
`define SPARSE_POLYNOMIAL_MERGE_ADD_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define SPMA_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("%m: implication check failed");
`define SPMA_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("%m: next-cycle check failed");
`else
`define SPMA_ASSERT_IMPL(label, pre, post)
`define SPMA_ASSERT_NEXT(label, pre, post)
`endif

`endif

// ----- rtl/spma_pkg.sv -----
`timescale 1ns / 1ps

package spma_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int COEF_BITS_DEF = 16;
  localparam int EXP_BITS_DEF  = 8;

  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  // which heads the merge step consumes
  typedef struct packed {
    logic take_a;
    logic take_b;
  } sel_t;

endpackage

// ----- rtl/spma_store.sv -----
`timescale 1ns / 1ps

module spma_store #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 24
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/spma_merge_alu.sv -----
`timescale 1ns / 1ps

module spma_merge_alu #(
  parameter int COEF_BITS = 16,
  parameter int EXP_BITS  = 8
) (
  input  logic                        has_a,
  input  logic                        has_b,
  input  logic signed [COEF_BITS-1:0] coef_a,
  input  logic [EXP_BITS-1:0]         exp_a,
  input  logic signed [COEF_BITS-1:0] coef_b,
  input  logic [EXP_BITS-1:0]         exp_b,
  output spma_pkg::sel_t              sel,
  output logic signed [COEF_BITS:0]   sum_coef,
  output logic [EXP_BITS-1:0]         sum_exp
);
  import spma_pkg::*;

  logic                      a_gt_b;
  logic                      b_gt_a;
  logic signed [COEF_BITS:0] op_a;
  logic signed [COEF_BITS:0] op_b;

  always_comb begin
    a_gt_b     = exp_a > exp_b;
    b_gt_a     = exp_b > exp_a;
    // larger head exponent goes first, equal heads are both consumed
    sel.take_a = has_a && !(has_b && b_gt_a);
    sel.take_b = has_b && !(has_a && a_gt_b);
    op_a       = sel.take_a ? {coef_a[COEF_BITS-1], coef_a} : '0;
    op_b       = sel.take_b ? {coef_b[COEF_BITS-1], coef_b} : '0;
    sum_coef   = op_a + op_b;
    sum_exp    = sel.take_a ? exp_a : exp_b;
  end

endmodule

// ----- rtl/sparse_polynomial_merge_add_unit.sv -----
`timescale 1ns / 1ps
// loads: one term per cycle, one request accepted each cycle while idle
// start: each sum term is read from the stores in S_READ, then compared and added in S_EMIT,
//   and loaded into the output register; terms are produced one at a time, and the empty
//   sum takes the same path; an output stall holds the block in S_EMIT
// not ready from the start request until its last term is in the output register
// reset clears both term counts and the output valid; term stores stay undefined
`include "sparse_polynomial_merge_add_unit_assert.svh"

module sparse_polynomial_merge_add_unit #(
  parameter int MAX_TERMS = spma_pkg::MAX_TERMS_DEF,
  parameter int COEF_BITS = spma_pkg::COEF_BITS_DEF,
  parameter int EXP_BITS  = spma_pkg::EXP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  req_type,
  input  logic signed [COEF_BITS-1:0] term_coef,
  input  logic [EXP_BITS-1:0]         term_exp,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [COEF_BITS:0]   sum_coef,
  output logic [EXP_BITS-1:0]         sum_exp,
  output logic                        last_term,
  output logic                        empty_sum
);
  import spma_pkg::*;

  localparam int IDX_W  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W  = $clog2(MAX_TERMS + 1);
  localparam int TERM_W = COEF_BITS + EXP_BITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count_a;
  logic [CNT_W-1:0]   count_b;
  logic [CNT_W-1:0]   ia;
  logic [CNT_W-1:0]   ib;
  logic [CNT_W-1:0]   ia_next;
  logic [CNT_W-1:0]   ib_next;
  logic [TERM_W-1:0]  rd_a;
  logic [TERM_W-1:0]  rd_b;
  logic               accept;
  logic               we_a;
  logic               we_b;
  logic               has_a;
  logic               has_b;
  logic               both_empty;
  logic               merge_done;
  logic               out_free;
  logic               emit;
  sel_t               sel;
  logic signed [COEF_BITS:0] alu_coef;
  logic [EXP_BITS-1:0]       alu_exp;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign we_a     = accept && (req_type == REQ_LOAD_A) && (count_a < CNT_W'(MAX_TERMS));
  assign we_b     = accept && (req_type == REQ_LOAD_B) && (count_b < CNT_W'(MAX_TERMS));
  assign out_free = !out_valid || !out_stall;
  assign emit     = (state == S_EMIT) && out_free;

  spma_store #(.DEPTH(MAX_TERMS), .WIDTH(TERM_W)) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (count_a[IDX_W-1:0]),
    .wdata ({term_coef, term_exp}),
    .raddr (ia[IDX_W-1:0]),
    .rdata (rd_a)
  );

  spma_store #(.DEPTH(MAX_TERMS), .WIDTH(TERM_W)) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (count_b[IDX_W-1:0]),
    .wdata ({term_coef, term_exp}),
    .raddr (ib[IDX_W-1:0]),
    .rdata (rd_b)
  );

  assign has_a      = ia < count_a;
  assign has_b      = ib < count_b;
  assign both_empty = (count_a == '0) && (count_b == '0);

  spma_merge_alu #(.COEF_BITS(COEF_BITS), .EXP_BITS(EXP_BITS)) u_alu (
    .has_a    (has_a),
    .has_b    (has_b),
    .coef_a   (rd_a[TERM_W-1:EXP_BITS]),
    .exp_a    (rd_a[EXP_BITS-1:0]),
    .coef_b   (rd_b[TERM_W-1:EXP_BITS]),
    .exp_b    (rd_b[EXP_BITS-1:0]),
    .sel      (sel),
    .sum_coef (alu_coef),
    .sum_exp  (alu_exp)
  );

  assign ia_next    = ia + CNT_W'(sel.take_a);
  assign ib_next    = ib + CNT_W'(sel.take_b);
  assign merge_done = !(ia_next < count_a) && !(ib_next < count_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count_a   <= '0;
      count_b   <= '0;
      ia        <= '0;
      ib        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (we_a) begin
            count_a <= count_a + CNT_W'(1);
          end
          if (we_b) begin
            count_b <= count_b + CNT_W'(1);
          end
          if (accept && (req_type == REQ_START)) begin
            ia    <= '0;
            ib    <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            ia <= ia_next;
            ib <= ib_next;
            if (both_empty || merge_done) begin
              count_a <= '0;
              count_b <= '0;
              state   <= S_IDLE;
            end else begin
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload, loaded with the valid flag
  always_ff @(posedge clk) begin
    if (emit) begin
      if (both_empty) begin
        sum_coef  <= '0;
        sum_exp   <= '0;
        last_term <= 1'b1;
        empty_sum <= 1'b1;
      end else begin
        sum_coef  <= alu_coef;
        sum_exp   <= alu_exp;
        last_term <= merge_done;
        empty_sum <= 1'b0;
      end
    end
  end

  `SPMA_ASSERT_IMPL(a_count_a_bound, 1'b1, count_a <= CNT_W'(MAX_TERMS))
  `SPMA_ASSERT_IMPL(a_head_a_bound, state != S_IDLE, ia <= count_a)
  `SPMA_ASSERT_NEXT(a_clear_on_done, emit && merge_done, both_empty && (state == S_IDLE))
  `SPMA_ASSERT_IMPL(a_empty_is_last, out_valid && empty_sum, last_term && (sum_coef == '0) && (sum_exp == '0))

endmodule

// ----- tb/sv/tb_sparse_polynomial_merge_add_unit.sv -----
`timescale 1ns / 1ps

module tb_sparse_polynomial_merge_add_unit;
  import spma_pkg::*;

  localparam int MAX_T  = MAX_TERMS_DEF;
  localparam int COEF_W = COEF_BITS_DEF;
  localparam int EXP_W  = EXP_BITS_DEF;

  // request code that the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam int TARGET_ITEMS = 370;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIMIT   = 2000;

  typedef struct packed {
    logic signed [COEF_W:0] coef;
    logic [EXP_W-1:0]       exp;
    logic                   last;
    logic                   empty;
  } sum_term_t;

  class poly_sum_board;
    logic signed [COEF_W-1:0] coef_a[MAX_T];
    logic signed [COEF_W-1:0] coef_b[MAX_T];
    logic [EXP_W-1:0]         exp_a[MAX_T];
    logic [EXP_W-1:0]         exp_b[MAX_T];
    int                       count_a;
    int                       count_b;
    sum_term_t                pending[$];
    int                       errors;

    task report_mismatch(string msg);
      if (errors < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    // updates the term stores and queues the sum terms a start causes
    function void note_request(logic [1:0] kind, logic signed [COEF_W-1:0] coef,
                               logic [EXP_W-1:0] exp);
      int                     ia;
      int                     ib;
      bit                     ta;
      bit                     tb;
      sum_term_t              t;
      ia = 0;
      ib = 0;
      case (kind)
        REQ_LOAD_A: begin
          if (count_a < MAX_T) begin
            coef_a[count_a] = coef;
            exp_a[count_a]  = exp;
            count_a++;
          end
        end
        REQ_LOAD_B: begin
          if (count_b < MAX_T) begin
            coef_b[count_b] = coef;
            exp_b[count_b]  = exp;
            count_b++;
          end
        end
        REQ_START: begin
          if (count_a == 0 && count_b == 0) begin
            t.coef  = '0;
            t.exp   = '0;
            t.last  = 1'b1;
            t.empty = 1'b1;
            pending.push_back(t);
          end
          while (ia < count_a || ib < count_b) begin
            ta = ia < count_a;
            tb = ib < count_b;
            if (ta && tb) begin
              if (exp_a[ia] > exp_b[ib]) tb = 1'b0;
              else if (exp_b[ib] > exp_a[ia]) ta = 1'b0;
            end
            if (ta && tb) begin
              t.coef = coef_a[ia] + coef_b[ib];
              t.exp  = exp_a[ia];
              ia++;
              ib++;
            end else if (ta) begin
              t.coef = coef_a[ia];
              t.exp  = exp_a[ia];
              ia++;
            end else begin
              t.coef = coef_b[ib];
              t.exp  = exp_b[ib];
              ib++;
            end
            t.last  = !(ia < count_a || ib < count_b);
            t.empty = 1'b0;
            pending.push_back(t);
          end
          count_a = 0;
          count_b = 0;
        end
        default: ;
      endcase
    endfunction

    task check_term(sum_term_t got);
      sum_term_t want;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected sum term coef %0d exp %0d",
                                  got.coef, got.exp));
        return;
      end
      want = pending.pop_front();
      if (got.coef !== want.coef)
        report_mismatch($sformatf("sum_coef got %0d want %0d (exp %0d)",
                                  got.coef, want.coef, want.exp));
      if (got.exp !== want.exp)
        report_mismatch($sformatf("sum_exp got %0d want %0d", got.exp, want.exp));
      if (got.last !== want.last)
        report_mismatch($sformatf("last_term got %b want %b (exp %0d)",
                                  got.last, want.last, want.exp));
      if (got.empty !== want.empty)
        report_mismatch($sformatf("empty_sum got %b want %b", got.empty, want.empty));
    endtask
  endclass

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [1:0]               req_type;
  logic signed [COEF_W-1:0] term_coef;
  logic [EXP_W-1:0]         term_exp;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [COEF_W:0]   sum_coef;
  logic [EXP_W-1:0]         sum_exp;
  logic                     last_term;
  logic                     empty_sum;

  poly_sum_board board = new();
  int            sent_items = 0;
  int            idle_cycles = 0;
  bit            quiet = 1'b0;
  bit            hold_request = 1'b0;

  sparse_polynomial_merge_add_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .term_coef (term_coef),
    .term_exp  (term_exp),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sum_coef  (sum_coef),
    .sum_exp   (sum_exp),
    .last_term (last_term),
    .empty_sum (empty_sum)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // result side
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_term('{coef: sum_coef, exp: sum_exp, last: last_term,
                         empty: empty_sum});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stall bursts, plus one long hold-off
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else if (!rst && !quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 10);
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_request(input logic [1:0] kind, input logic signed [COEF_W-1:0] coef,
                              input logic [EXP_W-1:0] exp);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    req_type  <= kind;
    term_coef <= coef;
    term_exp  <= exp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(kind, coef, exp);
    if (kind != REQ_UNUSED) sent_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coef();
    case ($urandom_range(0, 7))
      0:       return {1'b0, {(COEF_W-1){1'b1}}};
      1:       return {1'b1, {(COEF_W-1){1'b0}}};
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic void fill_exps(ref logic [EXP_W-1:0] e[], input int top,
                                    input bit shuffled);
    for (int i = 0; i < e.size(); i++) begin
      if (shuffled) begin
        e[i] = EXP_W'($urandom);
      end else begin
        e[i] = EXP_W'(top);
        top -= $urandom_range(1, 3);
      end
    end
  endfunction

  // loads two polynomials in random interleaving with occasional unused requests, then starts the merge
  task automatic merge_round(input int na, input int nb);
    logic [EXP_W-1:0] ea[];
    logic [EXP_W-1:0] eb[];
    int               ia;
    int               ib;
    int               top;
    ia  = 0;
    ib  = 0;
    top = $urandom_range(110, 255);
    ea  = new[na];
    eb  = new[nb];
    fill_exps(ea, top, $urandom_range(0, 5) == 0);
    fill_exps(eb, top, $urandom_range(0, 5) == 0);
    while (ia < na || ib < nb) begin
      if ($urandom_range(0, 19) == 0)
        send_request(REQ_UNUSED, COEF_W'($urandom), EXP_W'($urandom));
      if (ia < na && (ib >= nb || $urandom_range(0, 1) == 1)) begin
        send_request(REQ_LOAD_A, pick_coef(), ea[ia]);
        ia++;
      end else begin
        send_request(REQ_LOAD_B, pick_coef(), eb[ib]);
        ib++;
      end
    end
    send_request(REQ_START, COEF_W'($urandom), EXP_W'($urandom));
  endtask

  initial begin
    int na;
    int nb;
    bit held;
    bit paused;
    held      = 1'b0;
    paused    = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    req_type  = REQ_LOAD_A;
    term_coef = '0;
    term_exp  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // both polynomials empty
    send_request(REQ_START, 16'sd0, 8'd0);
    // extremes on both sides, matching exponents
    send_request(REQ_LOAD_A, 16'sh7fff, 8'd255);
    send_request(REQ_LOAD_A, 16'sh8000, 8'd0);
    send_request(REQ_LOAD_B, 16'sh7fff, 8'd255);
    send_request(REQ_LOAD_B, 16'sh8000, 8'd0);
    send_request(REQ_START, 16'sh7fff, 8'd255);
    // cancelling coefficients still give a term, unused code in between
    send_request(REQ_LOAD_A, 16'sd5, 8'd10);
    send_request(REQ_UNUSED, -16'sd1, 8'd255);
    send_request(REQ_LOAD_B, -16'sd5, 8'd10);
    send_request(REQ_START, 16'sd0, 8'd0);
    // only one polynomial loaded
    send_request(REQ_LOAD_A, 16'sd7, 8'd200);
    send_request(REQ_LOAD_A, -16'sd3, 8'd1);
    send_request(REQ_START, 16'sd0, 8'd0);
    send_request(REQ_LOAD_B, -16'sd1, 8'd128);
    send_request(REQ_START, 16'sd0, 8'd0);
    // ascending order in one store, merge only compares heads
    send_request(REQ_LOAD_A, 16'sd1, 8'd3);
    send_request(REQ_LOAD_A, 16'sd2, 8'd200);
    send_request(REQ_LOAD_B, 16'sd4, 8'd100);
    send_request(REQ_START, 16'sd0, 8'd0);
    wait_drained();

    // both stores overflow first
    merge_round(34, 33);
    while (sent_items < TARGET_ITEMS) begin
      if (!held && sent_items >= 110) begin
        hold_request = 1'b1;
        held = 1'b1;
      end
      if (!paused && sent_items >= 220) begin
        wait_drained();
        paused = 1'b1;
      end
      if (sent_items >= 300) quiet = 1'b1;
      na = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 6);
      nb = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(0, 6);
      merge_round(na, nb);
    end
    wait_drained();

    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
